### src/sorted_stack_insert_defines.svh
// Assertion macros for the sorted stack insert block.
`ifndef SORTED_STACK_INSERT_DEFINES_SVH
`define SORTED_STACK_INSERT_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define SSI_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("sorted_stack_insert: assertion failed");

`define SSI_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("sorted_stack_insert: assertion failed");

`else

`define SSI_ASSERT_NOW(label, pre, post)

`define SSI_ASSERT_NEXT(label, pre, post)

`endif

`endif

### src/ssi_pkg.sv
// Types and constants for the sorted stack insert block.
`default_nettype none

package ssi_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam int unsigned VAL_W   = 32;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned ERR_W   = 2;

  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned RES_W       = VAL_W + COUNT_W + 2 + ERR_W;
  localparam int unsigned OUT_TDATA_W = ((RES_W + 7) / 8) * 8;
  localparam int unsigned PAD_W       = OUT_TDATA_W - RES_W;

  typedef logic signed [VAL_W-1:0] val_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_POP    = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE      = 2'd0,
    ERR_OVERFLOW  = 2'd1,
    ERR_UNDERFLOW = 2'd2
  } err_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_FILL  = 4'b0100,
    ST_POPRD = 4'b1000
  } state_e;

endpackage

`default_nettype wire

### src/sorted_stack_insert.sv
// Sorted stack insert: top level with entry memory and command sequencer.
// A transaction carries a command (push, sorted insert, pop, no-op) and returns one result
// transaction with the top or popped value, the count, empty and full flags and an error
// code. Push, no-op, overflow, underflow and an insert that lands on top complete at the edge
// that takes the command. A pop that leaves entries also passes through ST_POPRD, where the new
// top is read back from the entry memory. A sorted insert that passes entries smaller than the
// operand then runs ST_SCAN and/or ST_FILL: the single-port-read, single-port-write entry memory
// moves one entry per cycle. The result of every command is registered at the edge that takes
// the command; the follow-up memory work runs behind it while the input side holds tready low.
`default_nettype none

`include "sorted_stack_insert_defines.svh"

module sorted_stack_insert (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output      logic                               s_axis_tready,
  input  wire logic [ssi_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // operand[31:0]
  input  wire logic [ssi_pkg::CMD_W-1:0]          s_axis_tuser,  // cmd[1:0]
  output      logic                               m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // value[31:0], count[38:32], empty_res[39], full_res[40], error[42:41], zero pad
  output      logic [ssi_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  ssi_pkg::val_t mem [ssi_pkg::DEPTH];
  ssi_pkg::val_t mem_rdata_q;
  logic                      mem_we, mem_re;
  logic [ssi_pkg::IDX_W-1:0] mem_waddr, mem_raddr;
  ssi_pkg::val_t             mem_wdata;

  ssi_pkg::state_e           state_q, state_d;
  logic [ssi_pkg::CNT_W-1:0] fill_q, fill_d;
  ssi_pkg::val_t             top_q, top_d;
  ssi_pkg::val_t             opnd_q, opnd_d;
  logic [ssi_pkg::IDX_W-1:0] hole_q, hole_d;
  logic                      m_valid_q, m_valid_d;
  logic [ssi_pkg::OUT_TDATA_W-1:0] m_data_q, m_data_d;

  logic                      in_acc, out_free, is_full, is_empty, out_load;
  ssi_pkg::cmd_e             in_cmd;
  ssi_pkg::val_t             in_opnd;
  ssi_pkg::val_t             res_value;
  ssi_pkg::err_e             res_err;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

  assign in_cmd   = ssi_pkg::cmd_e'(s_axis_tuser);
  assign in_opnd  = ssi_pkg::val_t'(s_axis_tdata[ssi_pkg::VAL_W-1:0]);
  assign out_free = !m_valid_q || m_axis_tready;
  assign is_full  = (fill_q == ssi_pkg::CNT_W'(ssi_pkg::DEPTH));
  assign is_empty = (fill_q == '0);

  assign s_axis_tready = (state_q == ssi_pkg::ST_IDLE) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    top_d     = top_q;
    opnd_d    = opnd_q;
    hole_d    = hole_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    out_load  = 1'b0;
    res_value = '0;
    res_err   = ssi_pkg::ERR_NONE;

    case (state_q)
      ssi_pkg::ST_IDLE: begin
        if (in_acc) begin
          out_load = 1'b1;
          case (in_cmd)
            ssi_pkg::CMD_PUSH, ssi_pkg::CMD_INSERT: begin
              if (is_full) begin
                res_err   = ssi_pkg::ERR_OVERFLOW;
                res_value = top_q;
              end else if (in_cmd == ssi_pkg::CMD_PUSH || is_empty || !(top_q < in_opnd)) begin
                mem_we    = 1'b1;
                mem_waddr = ssi_pkg::IDX_W'(fill_q);
                mem_wdata = in_opnd;
                top_d     = in_opnd;
                fill_d    = fill_q + ssi_pkg::CNT_W'(1);
                res_value = in_opnd;
              end else begin
                // operand sinks below the top: shift the top up, then scan down
                mem_we    = 1'b1;
                mem_waddr = ssi_pkg::IDX_W'(fill_q);
                mem_wdata = top_q;
                fill_d    = fill_q + ssi_pkg::CNT_W'(1);
                res_value = top_q;
                opnd_d    = in_opnd;
                hole_d    = ssi_pkg::IDX_W'(fill_q - ssi_pkg::CNT_W'(1));
                if (fill_q == ssi_pkg::CNT_W'(1)) begin
                  state_d = ssi_pkg::ST_FILL;
                end else begin
                  mem_re    = 1'b1;
                  mem_raddr = ssi_pkg::IDX_W'(fill_q - ssi_pkg::CNT_W'(2));
                  state_d   = ssi_pkg::ST_SCAN;
                end
              end
            end
            ssi_pkg::CMD_POP: begin
              if (is_empty) begin
                res_err = ssi_pkg::ERR_UNDERFLOW;
              end else begin
                res_value = top_q;
                fill_d    = fill_q - ssi_pkg::CNT_W'(1);
                if (fill_q > ssi_pkg::CNT_W'(1)) begin
                  mem_re    = 1'b1;
                  mem_raddr = ssi_pkg::IDX_W'(fill_q - ssi_pkg::CNT_W'(2));
                  state_d   = ssi_pkg::ST_POPRD;
                end
              end
            end
            default: begin
              res_value = is_empty ? '0 : top_q;
            end
          endcase
        end
      end
      ssi_pkg::ST_POPRD: begin
        top_d   = mem_rdata_q;
        state_d = ssi_pkg::ST_IDLE;
      end
      ssi_pkg::ST_SCAN: begin
        mem_we    = 1'b1;
        mem_waddr = hole_q;
        if (mem_rdata_q < opnd_q) begin
          mem_wdata = mem_rdata_q;
          hole_d    = hole_q - ssi_pkg::IDX_W'(1);
          if (hole_q == ssi_pkg::IDX_W'(1)) begin
            state_d = ssi_pkg::ST_FILL;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = hole_q - ssi_pkg::IDX_W'(2);
          end
        end else begin
          mem_wdata = opnd_q;
          state_d   = ssi_pkg::ST_IDLE;
        end
      end
      ssi_pkg::ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = hole_q;
        mem_wdata = opnd_q;
        state_d   = ssi_pkg::ST_IDLE;
      end
      default: begin
        state_d = ssi_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    if (out_load) begin
      m_valid_d = 1'b1;
      m_data_d  = {ssi_pkg::PAD_W'(0),
                   res_err,
                   (fill_d == ssi_pkg::CNT_W'(ssi_pkg::DEPTH)),
                   (fill_d == '0),
                   ssi_pkg::COUNT_W'(fill_d),
                   res_value};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ssi_pkg::ST_IDLE;
      fill_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q    <= top_d;
    opnd_q   <= opnd_d;
    hole_q   <= hole_d;
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  `SSI_ASSERT_NOW(a_fill_range, 1'b1, fill_q <= ssi_pkg::CNT_W'(ssi_pkg::DEPTH))
  `SSI_ASSERT_NOW(a_busy_stall, state_q != ssi_pkg::ST_IDLE, !s_axis_tready)
  `SSI_ASSERT_NOW(a_scan_hole, state_q == ssi_pkg::ST_SCAN, hole_q != '0)
  `SSI_ASSERT_NEXT(a_push_count, in_acc && in_cmd == ssi_pkg::CMD_PUSH && !is_full,
                   fill_q == $past(fill_q) + ssi_pkg::CNT_W'(1))

endmodule

`default_nettype wire
